>>> hdl/dscr_pkg.sv
// Shared types and constants for the dual serial controller register block.
// No dependencies.
package dscr_pkg;

  localparam logic [2:0] CMD_CTRL_RD = 3'd0;
  localparam logic [2:0] CMD_CTRL_WR = 3'd1;
  localparam logic [2:0] CMD_DATA_RD = 3'd2;
  localparam logic [2:0] CMD_DATA_WR = 3'd3;
  localparam logic [2:0] CMD_LINE    = 3'd4;
  localparam logic [2:0] CMD_BAUD    = 3'd5;
  localparam logic [2:0] CMD_TXDONE  = 3'd6;
  localparam logic [2:0] CMD_RXTICK  = 3'd7;

  // interrupt want / timer pending bit positions
  localparam int W_ZC = 0;
  localparam int W_TX = 1;
  localparam int W_RX = 2;
  localparam int T_BR = 0;
  localparam int T_TX = 1;
  localparam int T_RX = 2;

  localparam logic [7:0] RR0_BASE  = 8'h68;
  localparam logic [7:0] RR1_VAL   = 8'h07;
  localparam logic [7:0] WR15_RST  = 8'hf8;
  localparam logic [7:0] WR11_RST  = 8'h08;
  localparam logic [7:0] WR4_RST   = 8'h04;
  localparam logic [7:0] TX_MASK   = 8'h7f;

  // WR0 command codes (bits 5:3)
  localparam logic [2:0] WR0_RST_EXT  = 3'd2;
  localparam logic [2:0] WR0_BAD_A    = 3'd3;
  localparam logic [2:0] WR0_BAD_B    = 3'd4;
  localparam logic [2:0] WR0_RST_TX   = 3'd5;
  localparam logic [2:0] WR0_RST_IUS  = 3'd7;
  localparam logic [2:0] DPLL_BRG     = 3'd4;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       start_baud_timer;
    logic       start_tx_timer;
    logic       start_rx_timer;
    logic       tx_valid;
    logic [6:0] tx_char;
    logic       line_overflow;
    logic       unsupported;
  } res_t;

endpackage

>>> hdl/dual_serial_controller_regs.sv
// Dual serial controller register block: top level, single module.
// Depends on dscr_pkg.
//
// Usage: one input word per bus access or event (in_cmd, in_port, in_value)
// on a valid/stall channel; each word yields exactly one result word on the
// out_ channel (read data, irq level, timer start requests, transmitted
// character, overflow and unsupported flags).
// Each word waits in the input register; once out_stall does not hold the
// result register, that register loads the result and out_valid rises.
// Throughput: one word per cycle unless out_stall holds the result; the whole
// step for a word is one logic pass from input register to result register.
// The line ring per channel is a memory with registered read; its head entry
// is prefetched each cycle from the next read index, with write bypass, so a
// receive pull never waits on the memory port.
// Reset (rst_n low, synchronous): pointers, registers, FIFOs, ring indices,
// interrupt wants and timer-pending bits return to their power-up values;
// no clearing pass is needed, ring contents are only read once written.
// When the receiver holds out_stall, the result register holds its word, the
// input register fills, and then in_stall rises until the result is taken.
module dual_serial_controller_regs #(
  parameter int LINE_RING_DEPTH = 256,
  parameter int RX_FIFO_DEPTH   = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic       in_port,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq,
  output logic       out_start_baud_timer,
  output logic       out_start_tx_timer,
  output logic       out_start_rx_timer,
  output logic       out_tx_valid,
  output logic [6:0] out_tx_char,
  output logic       out_line_overflow,
  output logic       out_unsupported
);

  localparam int IW = $clog2(LINE_RING_DEPTH);
  localparam int CW = $clog2(RX_FIFO_DEPTH + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(LINE_RING_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(RX_FIFO_DEPTH);

  // ---- input register ----
  logic       s1_valid_r;
  logic [2:0] s1_cmd_r;
  logic       s1_port_r;
  logic [7:0] s1_value_r;
  logic       advance;

  // ---- result register ----
  logic            out_valid_r;
  dscr_pkg::res_t  res_r, res_nxt;

  // ---- architectural state ----
  logic [3:0]    ptr_r    [2];
  logic          armed_r  [2];
  logic [7:0]    wreg_r   [2][16];
  logic [7:0]    master_r;
  logic          txe_r    [2];
  logic [2:0]    want_r   [2];
  logic [2:0]    tpend_r  [2];
  logic [7:0]    fifo_r   [2][RX_FIFO_DEPTH];
  logic [CW-1:0] cnt_r    [2];
  logic [IW-1:0] ri_r     [2];
  logic [IW-1:0] wi_r     [2];
  logic [7:0]    head_r   [2];

  logic [3:0]    ptr_nxt    [2];
  logic          armed_nxt  [2];
  logic [7:0]    wreg_nxt   [2][16];
  logic [7:0]    master_nxt;
  logic          txe_nxt    [2];
  logic [2:0]    want_nxt   [2];
  logic [2:0]    tpend_nxt  [2];
  logic [7:0]    fifo_nxt   [2][RX_FIFO_DEPTH];
  logic [CW-1:0] cnt_nxt    [2];
  logic [IW-1:0] ri_nxt     [2];
  logic [IW-1:0] wi_nxt     [2];

  // ring write request
  logic          ring_we;
  logic [IW-1:0] ring_waddr;

  assign advance   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_cmd_r   <= in_cmd;
      s1_port_r  <= in_port;
      s1_value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // ---- one step of the register model ----
  always_comb begin
    logic          p;
    logic [7:0]    v;
    logic [2:0]    pend;
    logic [3:0]    rn;
    logic [2:0]    starts;
    logic [7:0]    rd;
    logic          bad;
    logic          over;
    logic          txv;
    logic [6:0]    txc;
    logic          add;
    logic          pull_try;
    logic          empty_before;
    logic [7:0]    pull_val;
    logic [IW-1:0] wnext;
    logic [2:0]    pa;
    logic [2:0]    pb;
    logic [1:0]    m;

    ptr_nxt    = ptr_r;
    armed_nxt  = armed_r;
    wreg_nxt   = wreg_r;
    master_nxt = master_r;
    txe_nxt    = txe_r;
    want_nxt   = want_r;
    tpend_nxt  = tpend_r;
    fifo_nxt   = fifo_r;
    cnt_nxt    = cnt_r;
    ri_nxt     = ri_r;
    wi_nxt     = wi_r;

    p        = s1_port_r;
    v        = s1_value_r;
    pend     = master_r[3] ? want_r[p] : 3'd0;
    rn       = 4'd0;
    starts   = 3'd0;
    rd       = 8'd0;
    bad      = 1'b0;
    over     = 1'b0;
    txv      = 1'b0;
    txc      = 7'd0;
    add      = 1'b0;
    pull_try = 1'b0;
    empty_before = (ri_r[p] == wi_r[p]);
    wnext    = (wi_r[p] == IDX_LAST) ? '0 : wi_r[p] + 1'b1;
    pull_val = head_r[p];
    ring_we  = 1'b0;
    ring_waddr = wi_r[p];
    pa       = master_r[3] ? want_r[0] : 3'd0;
    pb       = master_r[3] ? want_r[1] : 3'd0;
    m        = 2'd0;

    if (s1_valid_r && advance) begin
      case (s1_cmd_r)
        dscr_pkg::CMD_CTRL_RD: begin
          armed_nxt[p] = 1'b0;
          case (ptr_r[p])
            4'd0, 4'd4: rd = dscr_pkg::RR0_BASE | {5'd0, txe_r[p], 1'b0, (cnt_r[p] != '0)};
            4'd1, 4'd5: rd = dscr_pkg::RR1_VAL;
            4'd2, 4'd6: begin
              if (!p) rd = wreg_r[0][2];
              else bad = 1'b1;
            end
            4'd3, 4'd7: begin
              if (!p) rd = {2'b00, pa, pb};
            end
            4'd9, 4'd13:  rd = wreg_r[p][13];
            4'd11, 4'd15: rd = wreg_r[p][15];
            4'd12:        rd = wreg_r[p][12];
            4'd10, 4'd14: rd = 8'd0;
            default:      bad = 1'b1;
          endcase
          ptr_nxt[p] = 4'd0;
        end
        dscr_pkg::CMD_CTRL_WR: begin
          if (!armed_r[p]) begin
            rn = 4'd0;
            if (v[7:4] == 4'd0) begin
              ptr_nxt[p]   = v[3:0];
              armed_nxt[p] = 1'b1;
            end
          end else begin
            rn = ptr_r[p];
            ptr_nxt[p]   = 4'd0;
            armed_nxt[p] = 1'b0;
          end
          case (rn)
            4'd0: begin
              case (v[5:3])
                dscr_pkg::WR0_RST_EXT: want_nxt[p][dscr_pkg::W_ZC] = 1'b0;
                dscr_pkg::WR0_RST_TX:  want_nxt[p][dscr_pkg::W_TX] = 1'b0;
                dscr_pkg::WR0_RST_IUS: begin
                  if (pend[dscr_pkg::W_RX])      want_nxt[p][dscr_pkg::W_RX] = 1'b0;
                  else if (pend[dscr_pkg::W_TX]) want_nxt[p][dscr_pkg::W_TX] = 1'b0;
                  else if (pend[dscr_pkg::W_ZC]) want_nxt[p][dscr_pkg::W_ZC] = 1'b0;
                end
                dscr_pkg::WR0_BAD_A, dscr_pkg::WR0_BAD_B: bad = 1'b1;
                default: ;
              endcase
              if (v[7:6] == 2'd1 || v[7:6] == 2'd2) bad = 1'b1;
            end
            4'd8: ;
            4'd9: begin
              for (int q = 0; q < 2; q++) begin
                if ((q == 0 && v[7]) || (q == 1 && v[6])) begin
                  wreg_nxt[q][15] = dscr_pkg::WR15_RST;
                  wreg_nxt[q][14] = wreg_nxt[q][14] & 8'h03;
                  wreg_nxt[q][10] = 8'd0;
                  wreg_nxt[q][5]  = wreg_nxt[q][5] & 8'h65;
                  wreg_nxt[q][4]  = wreg_nxt[q][4] | dscr_pkg::WR4_RST;
                  wreg_nxt[q][3]  = wreg_nxt[q][3] & 8'hfe;
                  wreg_nxt[q][1]  = wreg_nxt[q][1] & 8'hfe;
                  txe_nxt[q]  = 1'b1;
                  want_nxt[q] = 3'd0;
                  cnt_nxt[q]  = '0;
                end
                if (v[7:6] == 2'b11) begin
                  wreg_nxt[q][15] = dscr_pkg::WR15_RST;
                  wreg_nxt[q][14] = 8'd0;
                  wreg_nxt[q][13] = 8'd0;
                  wreg_nxt[q][12] = 8'd0;
                  wreg_nxt[q][11] = dscr_pkg::WR11_RST;
                  wreg_nxt[q][10] = 8'd0;
                  wreg_nxt[q][7]  = 8'd0;
                  wreg_nxt[q][6]  = 8'd0;
                  wreg_nxt[q][5]  = 8'd0;
                  wreg_nxt[q][4]  = dscr_pkg::WR4_RST;
                  wreg_nxt[q][3]  = 8'd0;
                  wreg_nxt[q][2]  = 8'd0;
                  wreg_nxt[q][1]  = 8'd0;
                end
              end
              master_nxt = v;
            end
            4'd14, 4'd15: begin
              wreg_nxt[p][rn] = v;
              if (wreg_nxt[p][14][0] && !tpend_r[p][dscr_pkg::T_BR] &&
                  wreg_nxt[p][15][1]) begin
                tpend_nxt[p][dscr_pkg::T_BR] = 1'b1;
                starts[dscr_pkg::T_BR] = 1'b1;
              end
            end
            default: wreg_nxt[p][rn] = v;
          endcase
        end
        dscr_pkg::CMD_DATA_RD: begin
          if (cnt_r[p] != '0) begin
            rd = fifo_r[p][0];
            for (int k = 0; k < RX_FIFO_DEPTH - 1; k++) begin
              fifo_nxt[p][k] = fifo_r[p][k+1];
            end
            cnt_nxt[p] = cnt_r[p] - 1'b1;
            pull_try = 1'b1;
          end
        end
        dscr_pkg::CMD_DATA_WR: begin
          if (wreg_r[p][14][4]) begin
            add = 1'b1;
          end else if (txe_r[p]) begin
            txv = 1'b1;
            txc = v[6:0];
          end
          if (tpend_r[p][dscr_pkg::T_TX]) begin
            txe_nxt[p] = 1'b0;
          end else begin
            tpend_nxt[p][dscr_pkg::T_TX] = 1'b1;
            starts[dscr_pkg::T_TX] = 1'b1;
          end
        end
        dscr_pkg::CMD_LINE: add = 1'b1;
        dscr_pkg::CMD_BAUD: begin
          tpend_nxt[p][dscr_pkg::T_BR] = 1'b0;
          if (wreg_r[p][15][1]) want_nxt[p][dscr_pkg::W_ZC] = 1'b1;
          if (wreg_r[p][14][0] && wreg_r[p][15][1]) begin
            tpend_nxt[p][dscr_pkg::T_BR] = 1'b1;
            starts[dscr_pkg::T_BR] = 1'b1;
          end
        end
        dscr_pkg::CMD_TXDONE: begin
          tpend_nxt[p][dscr_pkg::T_TX] = 1'b0;
          txe_nxt[p] = 1'b1;
          if (wreg_r[p][1][1]) want_nxt[p][dscr_pkg::W_TX] = 1'b1;
        end
        default: begin
          tpend_nxt[p][dscr_pkg::T_RX] = 1'b0;
          pull_try = 1'b1;
        end
      endcase

      // line character into the ring, then a pull attempt
      if (add) begin
        pull_try = 1'b1;
        if (wnext != ri_r[p]) begin
          ring_we   = 1'b1;
          wi_nxt[p] = wnext;
          if (empty_before) pull_val = v;
        end else begin
          over = 1'b1;
        end
      end

      if (pull_try && !tpend_nxt[p][dscr_pkg::T_RX] && ri_r[p] != wi_nxt[p] &&
          cnt_nxt[p] < CNT_FULL) begin
        for (int k = 0; k < RX_FIFO_DEPTH; k++) begin
          if (cnt_nxt[p] == CW'(k)) fifo_nxt[p][k] = pull_val;
        end
        ri_nxt[p]  = (ri_r[p] == IDX_LAST) ? '0 : ri_r[p] + 1'b1;
        cnt_nxt[p] = cnt_nxt[p] + 1'b1;
        tpend_nxt[p][dscr_pkg::T_RX] = 1'b1;
        starts[dscr_pkg::T_RX] = 1'b1;
        m = wreg_r[p][1][4:3];
        if (m == 2'd1 || m == 2'd2) want_nxt[p][dscr_pkg::W_RX] = 1'b1;
      end

      // receive interrupt recheck after a data read
      if (s1_cmd_r == dscr_pkg::CMD_DATA_RD && cnt_r[p] != '0) begin
        m = wreg_r[p][1][4:3];
        if (cnt_nxt[p] == '0) want_nxt[p][dscr_pkg::W_RX] = 1'b0;
        else if (m == 2'd1 || m == 2'd2) want_nxt[p][dscr_pkg::W_RX] = 1'b1;
      end
    end

    res_nxt.read_data        = rd;
    res_nxt.irq              = master_nxt[3] && ((want_nxt[0] | want_nxt[1]) != 3'd0);
    res_nxt.start_baud_timer = starts[dscr_pkg::T_BR];
    res_nxt.start_tx_timer   = starts[dscr_pkg::T_TX];
    res_nxt.start_rx_timer   = starts[dscr_pkg::T_RX];
    res_nxt.tx_valid         = txv;
    res_nxt.tx_char          = txc;
    res_nxt.line_overflow    = over;
    res_nxt.unsupported      = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= 8'd0;
      for (int q = 0; q < 2; q++) begin
        ptr_r[q]   <= 4'd0;
        armed_r[q] <= 1'b0;
        txe_r[q]   <= 1'b1;
        want_r[q]  <= 3'd0;
        tpend_r[q] <= 3'd0;
        cnt_r[q]   <= '0;
        ri_r[q]    <= '0;
        wi_r[q]    <= '0;
        for (int k = 0; k < 16; k++) begin
          wreg_r[q][k] <= 8'd0;
        end
        wreg_r[q][4]  <= dscr_pkg::WR4_RST;
        wreg_r[q][11] <= dscr_pkg::WR11_RST;
        wreg_r[q][15] <= dscr_pkg::WR15_RST;
      end
    end else begin
      master_r <= master_nxt;
      ptr_r    <= ptr_nxt;
      armed_r  <= armed_nxt;
      txe_r    <= txe_nxt;
      want_r   <= want_nxt;
      tpend_r  <= tpend_nxt;
      cnt_r    <= cnt_nxt;
      ri_r     <= ri_nxt;
      wi_r     <= wi_nxt;
      wreg_r   <= wreg_nxt;
    end
  end

  // FIFO payload, no reset
  always_ff @(posedge clk) begin
    fifo_r <= fifo_nxt;
  end

  // ---- line ring memories, one per channel ----
  for (genvar g = 0; g < 2; g++) begin : g_ring
    logic [7:0] ring_mem [LINE_RING_DEPTH];
    logic       we_g;
    assign we_g = ring_we && (s1_port_r == 1'(g));
    always_ff @(posedge clk) begin
      if (we_g) begin
        ring_mem[ring_waddr] <= s1_value_r;
      end
      // prefetch head at next read index; bypass a same-cycle write
      if (we_g && ring_waddr == ri_nxt[g]) begin
        head_r[g] <= s1_value_r;
      end else begin
        head_r[g] <= ring_mem[ri_nxt[g]];
      end
    end
  end

  assign out_read_data        = res_r.read_data;
  assign out_irq              = res_r.irq;
  assign out_start_baud_timer = res_r.start_baud_timer;
  assign out_start_tx_timer   = res_r.start_tx_timer;
  assign out_start_rx_timer   = res_r.start_rx_timer;
  assign out_tx_valid         = res_r.tx_valid;
  assign out_tx_char          = res_r.tx_char;
  assign out_line_overflow    = res_r.line_overflow;
  assign out_unsupported      = res_r.unsupported;

  // ---- assertions ----
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CNT_FULL && cnt_r[1] <= CNT_FULL)
    else $error("rx fifo count beyond depth");

  a_ring_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ri_r[0] <= IDX_LAST && wi_r[0] <= IDX_LAST && ri_r[1] <= IDX_LAST && wi_r[1] <= IDX_LAST)
    else $error("ring index out of range");

  a_tx_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.tx_valid |-> res_r.tx_char == 7'd0)
    else $error("tx char without tx valid");

  a_rx_timer: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.start_rx_timer |=> tpend_r[$past(s1_port_r)][dscr_pkg::T_RX])
    else $error("rx timer start without pending bit");

endmodule
